// ===== design/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

    localparam int COORD_W = 11;
    localparam int AXIS_W  = 10;
    localparam int SQ_W    = 2 * AXIS_W;
    localparam int PROD_W  = SQ_W + COORD_W;
    localparam int DEC_W   = 48;
    localparam int PIX_W   = 13;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_A       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_B       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MAX_Y = 3'd4;

    localparam logic [COORD_W-1:0] SCREEN_MAX_Y_RST = 11'd479;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [AXIS_W-1:0]  semi_a;
        logic [AXIS_W-1:0]  semi_b;
        logic [COORD_W-1:0] screen_max_y;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_SQA,
        OP_SQB,
        OP_INI1,
        OP_INI2,
        OP_CAPT,
        OP_CLEAR,
        OP_STEP,
        OP_MU,
        OP_MV,
        OP_UPD,
        OP_X1,
        OP_X2
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   reg2;
        logic   load_out;
        logic   last;
    } dp_cmd_t;

    typedef struct packed {
        logic cont;
    } dp_stat_t;

    typedef struct packed {
        logic                    point_valid;
        logic signed [PIX_W-1:0] right_x;
        logic signed [PIX_W-1:0] left_x;
        logic signed [PIX_W-1:0] upper_y;
        logic signed [PIX_W-1:0] lower_y;
        logic                    region;
        logic                    last_point;
    } out_beat_t;

endpackage

`default_nettype wire

// ===== design/mer_cfg.sv =====
// ----------------------------------------------------------------------------
// mer_cfg
// Configuration register file: center, semi-axes and top screen row.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mer_pkg::CFG_DATA_W-1:0] cfg_data,
    output mer_pkg::cfg_t                       cfg
);
    import mer_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_x     <= '0;
            cfg_reg.center_y     <= '0;
            cfg_reg.semi_a       <= '0;
            cfg_reg.semi_b       <= '0;
            cfg_reg.screen_max_y <= SCREEN_MAX_Y_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CENTER_X:     cfg_reg.center_x     <= cfg_data[COORD_W-1:0];
                CFG_CENTER_Y:     cfg_reg.center_y     <= cfg_data[COORD_W-1:0];
                CFG_SEMI_A:       cfg_reg.semi_a       <= cfg_data[AXIS_W-1:0];
                CFG_SEMI_B:       cfg_reg.semi_b       <= cfg_data[AXIS_W-1:0];
                CFG_SCREEN_MAX_Y: cfg_reg.screen_max_y <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/mer_datapath.sv =====
// ----------------------------------------------------------------------------
// mer_datapath
// Offsets, decision value, one shared 20x11 multiplier and the pixel
// hold and output registers, driven one operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_datapath #(
    parameter int AXIS_MAX = 1023
) (
    input  wire logic            aclk,
    input  wire mer_pkg::cfg_t   cfg,
    input  wire mer_pkg::dp_cmd_t cmd,
    output mer_pkg::dp_stat_t    stat,
    output mer_pkg::out_beat_t   beat
);
    import mer_pkg::*;

    localparam logic [AXIS_W+1:0] AXIS_LIM = (AXIS_W + 2)'(AXIS_MAX);

    logic [COORD_W-1:0]      lat_cx_reg, lat_cy_reg;
    logic [AXIS_W-1:0]       lat_a_reg, lat_b_reg;
    logic [SQ_W-1:0]         a2_reg, b2_reg;
    logic [COORD_W-1:0]      x_reg, y_reg;
    logic signed [DEC_W-1:0] d_reg;
    logic                    dpos_reg;
    logic [PROD_W-1:0]       prod_reg, pu_reg;
    out_beat_t               hold_reg, out_reg;
    out_beat_t               out_next;

    logic [AXIS_W-1:0]       a_clamp, b_clamp;
    logic [SQ_W-1:0]         mul_a, cu, cv;
    logic [COORD_W-1:0]      mul_b, u, v, u_new, v_new;
    logic [AXIS_W-1:0]       lim;
    logic                    dpos_now;
    logic signed [DEC_W-1:0] a2_e, b2_e, cu_e, pu_e, prod_e, sub_e;
    logic [PIX_W-1:0]        cx13, cy13, top13, x13, y13;

    assign a_clamp = ({2'b00, cfg.semi_a} > AXIS_LIM) ? AXIS_LIM[AXIS_W-1:0] : cfg.semi_a;
    assign b_clamp = ({2'b00, cfg.semi_b} > AXIS_LIM) ? AXIS_LIM[AXIS_W-1:0] : cfg.semi_b;

    // region I steps x against b^2, region II steps y against a^2
    assign cu  = cmd.reg2 ? a2_reg : b2_reg;
    assign cv  = cmd.reg2 ? b2_reg : a2_reg;
    assign u   = cmd.reg2 ? y_reg  : x_reg;
    assign v   = cmd.reg2 ? x_reg  : y_reg;
    assign lim = cmd.reg2 ? lat_b_reg : lat_a_reg;

    assign dpos_now = (d_reg > 0);
    assign u_new    = u + 1'b1;
    assign v_new    = (dpos_now && v != '0) ? v - 1'b1 : v;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SQA: begin
                mul_a = SQ_W'(lat_a_reg);
                mul_b = COORD_W'(lat_a_reg);
            end
            OP_SQB: begin
                mul_a = SQ_W'(lat_b_reg);
                mul_b = COORD_W'(lat_b_reg);
            end
            OP_INI1: begin
                mul_a = a2_reg;
                mul_b = COORD_W'(lat_b_reg);
            end
            OP_MU: begin
                mul_a = cu;
                mul_b = u;
            end
            OP_MV: begin
                mul_a = cv;
                mul_b = v;
            end
            OP_X1: begin
                mul_a = b2_reg;
                mul_b = COORD_W'(lat_a_reg);
            end
            default: ;
        endcase
    end

    assign a2_e   = DEC_W'(a2_reg);
    assign b2_e   = DEC_W'(b2_reg);
    assign cu_e   = DEC_W'(cu);
    assign pu_e   = DEC_W'(pu_reg);
    assign prod_e = DEC_W'(prod_reg);
    assign sub_e  = dpos_reg ? (prod_e <<< 3) : '0;

    assign stat.cont = (pu_reg <= prod_reg) && (u <= {1'b0, lim});

    assign cx13  = PIX_W'(lat_cx_reg);
    assign cy13  = PIX_W'(lat_cy_reg);
    assign top13 = PIX_W'(cfg.screen_max_y);
    assign x13   = PIX_W'(x_reg);
    assign y13   = PIX_W'(y_reg);

    // the end mark only rides on a beat that carries a point
    always_comb begin
        out_next            = hold_reg;
        out_next.last_point = cmd.last && hold_reg.point_valid;
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LATCH: begin
                lat_cx_reg <= cfg.center_x;
                lat_cy_reg <= cfg.center_y;
                lat_a_reg  <= a_clamp;
                lat_b_reg  <= b_clamp;
            end
            OP_SQA, OP_MU, OP_X1: begin
                prod_reg <= mul_a * mul_b;
            end
            OP_SQB: begin
                a2_reg   <= prod_reg[SQ_W-1:0];
                prod_reg <= mul_a * mul_b;
            end
            OP_INI1: begin
                b2_reg   <= prod_reg[SQ_W-1:0];
                prod_reg <= mul_a * mul_b;
            end
            OP_INI2: begin
                d_reg <= (b2_e <<< 2) - (prod_e <<< 2) + a2_e;
                x_reg <= '0;
                y_reg <= COORD_W'(lat_b_reg);
            end
            OP_X2: begin
                d_reg <= (a2_e <<< 2) - (prod_e <<< 2) + b2_e;
                x_reg <= COORD_W'(lat_a_reg);
                y_reg <= '0;
            end
            OP_STEP: begin
                dpos_reg <= dpos_now;
                if (cmd.reg2) begin
                    y_reg <= u_new;
                    x_reg <= v_new;
                end else begin
                    x_reg <= u_new;
                    y_reg <= v_new;
                end
            end
            OP_MV: begin
                pu_reg   <= prod_reg;
                prod_reg <= mul_a * mul_b;
            end
            OP_UPD: begin
                d_reg <= d_reg + (pu_e <<< 3) + (cu_e <<< 2) - sub_e;
            end
            OP_CAPT: begin
                hold_reg.point_valid <= 1'b1;
                hold_reg.right_x     <= cx13 + x13;
                hold_reg.left_x      <= cx13 - x13;
                hold_reg.upper_y     <= top13 - cy13 - y13;
                hold_reg.lower_y     <= top13 - cy13 + y13;
                hold_reg.region      <= cmd.reg2;
                hold_reg.last_point  <= 1'b0;
            end
            OP_CLEAR: begin
                hold_reg <= '0;
            end
            default: ;
        endcase
        if (cmd.load_out) begin
            out_reg <= out_next;
        end
    end

    assign beat = out_reg;

endmodule

`default_nettype wire

// ===== design/mer_ctrl.sv =====
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer for the rasterizer: walk phase, per-beat operation order and
// the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_ctrl (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        restart,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output mer_pkg::dp_cmd_t cmd,
    input  wire mer_pkg::dp_stat_t stat
);
    import mer_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SQA,
        S_SQB,
        S_INI1,
        S_INI2,
        S_EMIT,
        S_ADV,
        S_MU,
        S_MV,
        S_UPD,
        S_X1,
        S_X2,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_REG1,
        PH_REG2,
        PH_DONE
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;
    logic   m_tvalid_reg;
    logic   active;
    logic   out_free;

    assign active   = (phase_reg == PH_REG1) || (phase_reg == PH_REG2);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.op       = OP_NONE;
        cmd.reg2     = (phase_reg == PH_REG2);
        cmd.load_out = 1'b0;
        cmd.last     = (phase_reg == PH_DONE);
        unique case (state_reg)
            S_LOAD: cmd.op = OP_LATCH;
            S_SQA:  cmd.op = OP_SQA;
            S_SQB:  cmd.op = OP_SQB;
            S_INI1: cmd.op = OP_INI1;
            S_INI2: cmd.op = OP_INI2;
            S_EMIT: cmd.op = active ? OP_CAPT : OP_CLEAR;
            S_ADV:  cmd.op = OP_STEP;
            S_MU:   cmd.op = OP_MU;
            S_MV:   cmd.op = OP_MV;
            S_UPD:  cmd.op = OP_UPD;
            S_X1:   cmd.op = OP_X1;
            S_X2:   cmd.op = OP_X2;
            S_OUT:  cmd.load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= restart ? S_LOAD : S_EMIT;
                    end
                end
                S_LOAD: state_reg <= S_SQA;
                S_SQA:  state_reg <= S_SQB;
                S_SQB:  state_reg <= S_INI1;
                S_INI1: state_reg <= S_INI2;
                S_INI2: begin
                    // the start point of region I always passes its test
                    phase_reg <= PH_REG1;
                    state_reg <= S_EMIT;
                end
                S_EMIT: state_reg <= active ? S_ADV : S_OUT;
                S_ADV:  state_reg <= S_MU;
                S_MU:   state_reg <= S_MV;
                S_MV:   state_reg <= S_UPD;
                S_UPD: begin
                    priority if (stat.cont) begin
                        state_reg <= S_OUT;
                    end else if (phase_reg == PH_REG1) begin
                        state_reg <= S_X1;
                    end else begin
                        phase_reg <= PH_DONE;
                        state_reg <= S_OUT;
                    end
                end
                S_X1:   state_reg <= S_X2;
                S_X2: begin
                    // region II start point always passes its test too
                    phase_reg <= PH_REG2;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/midpoint_ellipse_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_top
// Midpoint ellipse rasterizer: one four-way symmetric pixel group per beat.
// ----------------------------------------------------------------------------
// Usage:
// Write center, semi-axes and top screen row on the cfg channel (always
// ready) while the block is idle. Each s_ beat is a step tick; s_tdata[0]
// set restarts a new ellipse from the configuration. Every s_ beat yields
// exactly one m_ beat carrying the current point's four pixels (y flipped
// against the top row); m_tuser[0] clear means idle or finished, and
// m_tlast marks the final point of the ellipse.
// Timing: one beat is in work at a time. Handing over from region I to
// region II takes one more product on the shared multiplier, and a
// restart adds the latching and squaring of the axes. The single 20x11
// multiplier is used in turn for both decision products.
// A finished result sits in the output register; the next beat is taken
// while it waits, but its result is held back until m_tready frees the slot.
// Reset clears the walk to idle and the top row to 479.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_ellipse_rasterizer_top #(
    parameter int AXIS_MAX = 1023
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [12:0] pixel_right_x, [25:13] pixel_left_x,
                                        // [38:26] pixel_upper_y, [51:39] pixel_lower_y,
                                        // [55:52] zero
    output logic [1:0]       m_tuser,   // [0] point_valid, [1] region
    output logic             m_tlast,   // last_point
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);
    import mer_pkg::*;

    cfg_t      cfg;
    dp_cmd_t   cmd;
    dp_stat_t  stat;
    out_beat_t beat;

    mer_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mer_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .restart  (s_tdata[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    mer_datapath #(
        .AXIS_MAX (AXIS_MAX)
    ) u_datapath (
        .aclk (aclk),
        .cfg  (cfg),
        .cmd  (cmd),
        .stat (stat),
        .beat (beat)
    );

    assign m_tdata = {4'b0000, beat.lower_y, beat.upper_y, beat.left_x, beat.right_x};
    assign m_tuser = {beat.region, beat.point_valid};
    assign m_tlast = beat.last_point;

`ifndef SYNTHESIS
    // one beat in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a beat is still in work");

    // an empty result carries no pixels, region or end mark
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> !m_tlast && !m_tuser[1] && m_tdata == '0)
        else $error("empty result carries payload");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the midpoint ellipse rasterizer: drives step and
// restart beats, programs the configuration while no beat is in work, and compares
// every pixel group against a cycle-free model of the walk.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mer_pkg::*;

    typedef enum int {WALK_IDLE, WALK_REG1, WALK_REG2, WALK_DONE} walk_t;

    localparam int AXIS_LIMIT = 1023;

    class ellipse_scoreboard;
        logic [COORD_W-1:0] cx_reg, cy_reg, top_reg;
        logic [AXIS_W-1:0]  a_reg, b_reg;
        longint             cx_lat, cy_lat, axis_a, axis_b, a_sq, b_sq;
        longint             off_x, off_y, dec;
        walk_t              walk;
        out_beat_t          pixel_q[$];
        int                 errors, shown, results, restarts, walks_done, reg2_points;
        int                 reg_writes;

        function new();
            cx_reg = '0; cy_reg = '0; a_reg = '0; b_reg = '0;
            top_reg = SCREEN_MAX_Y_RST;
            cx_lat = 0; cy_lat = 0; axis_a = 0; axis_b = 0; a_sq = 0; b_sq = 0;
            off_x = 0; off_y = 0; dec = 0;
            walk = WALK_IDLE;
            errors = 0; shown = 0; results = 0; restarts = 0;
            walks_done = 0; reg2_points = 0; reg_writes = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            reg_writes++;
            case (idx)
                CFG_CENTER_X:     cx_reg  = val;
                CFG_CENTER_Y:     cy_reg  = val;
                CFG_SEMI_A:       a_reg   = val[AXIS_W-1:0];
                CFG_SEMI_B:       b_reg   = val[AXIS_W-1:0];
                CFG_SCREEN_MAX_Y: top_reg = val;
                default: ;
            endcase
        endfunction

        // hand over between regions, or finish, once the current region test fails
        function void settle_region();
            if (walk == WALK_REG1 &&
                !(b_sq * off_x <= a_sq * off_y && off_x <= axis_a)) begin
                walk  = WALK_REG2;
                off_x = axis_a;
                off_y = 0;
                dec   = 4 * a_sq - 4 * b_sq * axis_a + b_sq;
            end
            if (walk == WALK_REG2 &&
                !(a_sq * off_y <= b_sq * off_x && off_y <= axis_b))
                walk = WALK_DONE;
        endfunction

        function void advance_point();
            if (walk == WALK_REG1) begin
                off_x++;
                if (dec > 0) begin
                    if (off_y > 0) off_y--;
                    dec += 4 * (2 * b_sq * off_x + b_sq - 2 * a_sq * off_y);
                end else begin
                    dec += 4 * (b_sq + 2 * b_sq * off_x);
                end
            end else begin
                off_y++;
                if (dec > 0) begin
                    if (off_x > 0) off_x--;
                    dec += 4 * (2 * a_sq * off_y + a_sq - 2 * b_sq * off_x);
                end else begin
                    dec += 4 * (a_sq + 2 * a_sq * off_y);
                end
            end
            settle_region();
        endfunction

        function void note_step(bit restart);
            out_beat_t pix;
            longint    top;
            pix = '0;
            if (restart) begin
                restarts++;
                cx_lat = cx_reg;
                cy_lat = cy_reg;
                axis_a = (a_reg > AXIS_LIMIT) ? AXIS_LIMIT : a_reg;
                axis_b = (b_reg > AXIS_LIMIT) ? AXIS_LIMIT : b_reg;
                a_sq   = axis_a * axis_a;
                b_sq   = axis_b * axis_b;
                off_x  = 0;
                off_y  = axis_b;
                dec    = 4 * b_sq - 4 * a_sq * axis_b + a_sq;
                walk   = WALK_REG1;
                settle_region();
            end
            if (walk == WALK_REG1 || walk == WALK_REG2) begin
                top = top_reg;
                pix.point_valid = 1'b1;
                pix.right_x = PIX_W'(cx_lat + off_x);
                pix.left_x  = PIX_W'(cx_lat - off_x);
                pix.upper_y = PIX_W'(top - (cy_lat + off_y));
                pix.lower_y = PIX_W'(top - (cy_lat - off_y));
                pix.region  = (walk == WALK_REG2);
                if (walk == WALK_REG2) reg2_points++;
                advance_point();
                pix.last_point = (walk == WALK_DONE);
                if (walk == WALK_DONE) walks_done++;
            end
            pixel_q = {pixel_q, pix};
        endfunction

        function void check_point(logic [55:0] td, logic [1:0] tu, logic tl);
            out_beat_t got, want;
            got.right_x     = td[12:0];
            got.left_x      = td[25:13];
            got.upper_y     = td[38:26];
            got.lower_y     = td[51:39];
            got.point_valid = tu[0];
            got.region      = tu[1];
            got.last_point  = tl;
            results++;
            if (pixel_q.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("ERROR: unexpected result beat %0d", results);
                end
                return;
            end
            want = pixel_q.pop_front();
            if (got !== want) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("ERROR: beat %0d exp v=%0b rx=%0d lx=%0d uy=%0d ly=%0d r=%0b l=%0b",
                             results, want.point_valid, want.right_x, want.left_x,
                             want.upper_y, want.lower_y, want.region, want.last_point);
                    $display("       beat %0d got v=%0b rx=%0d lx=%0d uy=%0d ly=%0d r=%0b l=%0b",
                             results, got.point_valid, got.right_x, got.left_x,
                             got.upper_y, got.lower_y, got.region, got.last_point);
                end
            end
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [55:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ellipse_scoreboard sb = new();
    int  sent;
    bit  calm;
    bit  hold_req;

    midpoint_ellipse_rasterizer_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // result side: check every beat, random stalls plus one long hold-off
    initial begin : result_sink
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_point(m_tdata, m_tuser, m_tlast);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 12);
            end
        end
    end

    task automatic send_step(input bit restart);
        if (!calm)
            while ($urandom_range(0, 99) < 12) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        do @(posedge aclk); while (!s_tready);
        sb.note_step(restart);
        sent++;
    endtask

    task automatic run_steps(input int n, input bit first_restart, input int restart_pct);
        for (int k = 0; k < n; k++)
            send_step(k == 0 ? first_restart : ($urandom_range(0, 99) < restart_pct));
        s_tvalid <= 1'b0;
    endtask

    // every beat yields a result, so an empty queue means the block is idle
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [10:0] cx, input logic [10:0] cy,
                                input logic [10:0] a, input logic [10:0] b,
                                input logic [10:0] top, input bit [4:0] mask);
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        idx[0] = CFG_CENTER_X;     val[0] = cx;
        idx[1] = CFG_CENTER_Y;     val[1] = cy;
        idx[2] = CFG_SEMI_A;       val[2] = a;
        idx[3] = CFG_SEMI_B;       val[3] = b;
        idx[4] = CFG_SCREEN_MAX_Y; val[4] = top;
        for (int i = 0; i < 5; i++) begin
            if (mask[i]) begin
                cfg_valid <= 1'b1;
                cfg_index <= idx[i];
                cfg_data  <= val[i];
                do @(posedge aclk); while (!cfg_ready);
                sb.write_reg(idx[i], val[i]);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int          phase_no, n, pick;
        logic [10:0] ra, rb, rtop;
        sent     = 0;
        calm     = 0;
        hold_req = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_CENTER_X;
        cfg_data  <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no walk yet, then a restart on reset registers (zero axes)
        run_steps(1, 0, 0);
        run_steps(3, 1, 0);
        wait_drained();
        // extreme corners: wide-flat and tall-thin ellipses, partial walks
        program_regs(11'd2047, 11'd0, 11'd1, 11'd1023, 11'd2047, 5'b11111);
        run_steps(3, 1, 0);
        wait_drained();
        program_regs(11'd0, 11'd2047, 11'd1023, 11'd0, 11'd0, 5'b11111);
        run_steps(3, 1, 0);
        wait_drained();
        // complete small walk, then steps past the end
        program_regs(11'd100, 11'd200, 11'd3, 11'd2, 11'd479, 5'b11111);
        run_steps(9, 1, 0);
        wait_drained();
        // top row changes mid-walk and takes effect at once
        program_regs(11'd640, 11'd240, 11'd5, 11'd4, 11'd479, 5'b11111);
        run_steps(3, 1, 0);
        wait_drained();
        program_regs(11'd0, 11'd0, 11'd0, 11'd0, 11'd2047, 5'b10000);
        run_steps(3, 0, 0);
        wait_drained();

        phase_no = 0;
        while (sent < 390) begin
            calm = (phase_no >= 6 && phase_no < 10);
            if (phase_no == 3) begin
                // receiver holds off while the sender keeps offering
                program_regs(11'd1000, 11'd500, 11'd9, 11'd9, 11'd1023, 5'b11111);
                hold_req = 1;
                run_steps(30, 1, 0);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    ra = $urandom_range(0, 12);
                    rb = $urandom_range(0, 12);
                end else if (pick < 85) begin
                    ra = $urandom_range(0, 1) ? 11'd1023 : 11'd0;
                    rb = $urandom_range(0, 6);
                end else if (pick < 90) begin
                    ra = $urandom_range(0, 6);
                    rb = $urandom_range(0, 1) ? 11'd1023 : 11'd0;
                end else begin
                    ra = $urandom_range(0, 1023);
                    rb = $urandom_range(0, 1023);
                end
                rtop = ($urandom_range(0, 3) == 0) ? 11'd479 : 11'($urandom_range(0, 2047));
                n = ra + rb + 4;
                if (n > 60) n = 60;
                n += $urandom_range(0, 2);
                if ($urandom_range(0, 99) < 15) begin
                    // only the top row, walk continues
                    program_regs(11'd0, 11'd0, 11'd0, 11'd0, rtop, 5'b10000);
                    run_steps($urandom_range(3, 12), 0, 3);
                end else begin
                    program_regs(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                                 ra, rb, rtop, 5'($urandom_range(1, 31)) | 5'b01100);
                    run_steps(n, 1, 3);
                end
            end
            wait_drained();
            phase_no++;
        end
        calm = 0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("covered %0d step beats, %0d restarts, %0d finished walks, %0d region II points",
                 sent, sb.restarts, sb.walks_done, sb.reg2_points);
        $display("%0d register writes, %0d result beats, %0d mismatches",
                 sb.reg_writes, sb.results, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
